/* rtl/het_pkg.sv */
// ============================================================================
// het_pkg
// Shared types and constants of the hysteresis edge tracking block.
// ============================================================================
`default_nettype none

package het_pkg;

    localparam int PIXEL_W      = 8;
    localparam int IMG_WIDTH_W  = 13;
    localparam int IMG_HEIGHT_W = 12;
    localparam int APB_DATA_W   = 32;
    localparam int APB_ADDR_W   = 3;

    typedef logic [PIXEL_W-1:0]      pixel_t;
    typedef logic [IMG_WIDTH_W-1:0]  img_width_t;
    typedef logic [IMG_HEIGHT_W-1:0] img_height_t;
    typedef logic [APB_DATA_W-1:0]   apb_data_t;
    typedef logic [APB_ADDR_W-1:0]   apb_addr_t;

    localparam pixel_t GRAY_WEAK   = 8'd25;
    localparam pixel_t GRAY_STRONG = 8'd255;
    localparam pixel_t GRAY_BLACK  = 8'd0;

    localparam int RESET_WIDTH  = 640;
    localparam int RESET_HEIGHT = 480;

    typedef enum logic
    {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_type_t;

    typedef enum logic
    {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_index_t;

endpackage

`default_nettype wire

/* rtl/hysteresis_edge_tracking.sv */
// ============================================================================
// hysteresis_edge_tracking
// Canny hysteresis stage on a column-major stream of 8-bit gray pixels.
// ============================================================================
// Pixels enter on the s_ channel (tuser = 0) column by column, top to bottom.
// A weak pixel (25) leaves as 255 when one of its eight neighbors is strong
// and as 0 otherwise; every other value passes unchanged. A pixel is decided
// once height+1 later pixels have arrived, so a pixel transaction returns the
// result of the pixel height+1 places before it. A drain transaction
// (tuser = 1) returns the oldest pending result and is used to flush the tail
// of a frame; a drain with nothing pending returns nothing. tlast marks the
// final pixel of a frame.
// One transaction is accepted per clock unless the output stalls. Its result
// sits in the output register in the next cycle, and the next transaction is
// taken in the same cycle as that result is taken. The rate is set by the
// single read and single write port of each memory, the pending pixel queue
// and the decided strong bits, each port used at most once per transaction.
// When m_tready is low the output register holds its result and s_tready
// stays low until it is taken. Reset empties the queue and needs no clearing
// pass; a register write over the APB port also drops all pending pixels.
// ============================================================================
`default_nettype none

module hysteresis_edge_tracking #(
    parameter int MAX_HEIGHT = 2048,
    parameter int MAX_WIDTH  = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    // s_tdata: [7:0] pixel_in
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire het_pkg::pixel_t     s_tdata,
    // s_tuser: [0] req_type
    input  wire logic                s_tuser,
    // m_tdata: [7:0] pixel_out
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output het_pkg::pixel_t          m_tdata,
    output logic                     m_tlast,
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire het_pkg::apb_addr_t  paddr,
    input  wire het_pkg::apb_data_t  pwdata,
    output het_pkg::apb_data_t       prdata,
    output logic                     pready
);

    import het_pkg::*;

    localparam int FIFO_DEPTH = MAX_HEIGHT + 1;
    localparam int DMEM_DEPTH = MAX_HEIGHT + 2;
    localparam int FA_W       = $clog2(FIFO_DEPTH);
    localparam int DA_W       = $clog2(DMEM_DEPTH);
    localparam int CNT_W      = $clog2(MAX_HEIGHT + 2);
    localparam int ROW_W      = $clog2(MAX_HEIGHT);
    localparam int COL_W      = $clog2(MAX_WIDTH);
    localparam int RST_H      = (RESET_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RESET_HEIGHT;
    localparam int RST_W      = (RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RESET_WIDTH;
    localparam int RST_RP     = (RST_H <= 2) ? (2 - RST_H) : (DMEM_DEPTH + 2 - RST_H);
    localparam int HEAD3_INIT = 3 % FIFO_DEPTH;

    function automatic int unsigned clamp_val(input int unsigned v, input int unsigned hi);
        int unsigned t;
        t = v;
        if (t == 0)
        begin
            t = 1;
        end
        else if (t > hi)
        begin
            t = hi;
        end
        return t;
    endfunction

    function automatic logic [DA_W-1:0] rp_start(input int unsigned h);
        int unsigned t;
        t = (h <= 2) ? (2 - h) : (DMEM_DEPTH + 2 - h);
        return DA_W'(t);
    endfunction

    // Memories.
    pixel_t fifo_mem [FIFO_DEPTH];
    logic   dec_mem  [DMEM_DEPTH];

    // Registers.
    img_width_t      image_width_reg, image_width_next;
    img_height_t     image_height_reg, image_height_next;
    logic [CNT_W-1:0] h_reg, h_next;
    logic [ROW_W-1:0] hm1_reg, hm1_next;
    logic [COL_W-1:0] wm1_reg, wm1_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [COL_W-1:0] col_reg, col_next;
    logic [FA_W-1:0]  tail_reg, tail_next;
    logic [FA_W-1:0]  head3_reg, head3_next;
    pixel_t           s0_reg, s0_next;
    pixel_t           s1_reg, s1_next;
    logic             fbyp_reg, fbyp_next;
    pixel_t           fbyp_val_reg, fbyp_val_next;
    pixel_t           fq_reg;
    logic             last1_reg, last1_next;
    logic             last2_reg, last2_next;
    logic [DA_W-1:0]  wp_reg, wp_next;
    logic [DA_W-1:0]  rp_reg, rp_next;
    logic             dq_reg;
    logic             dbyp_reg, dbyp_next;
    logic             dbyp_val_reg, dbyp_val_next;
    logic             wa_reg, wa_next;
    logic             wb_reg, wb_next;
    logic             last_res_reg, last_res_next;
    logic             m_valid_reg, m_valid_next;
    pixel_t           m_data_reg, m_data_next;
    logic             m_last_reg, m_last_next;

    // Combinational decision signals.
    logic             accept;
    logic             have_in;
    logic             in_strong;
    logic             push;
    logic             pop;
    logic             cnt_full;
    logic             cnt_eq_h;
    logic             fifo_rd;
    logic [CNT_W-1:0] land;
    pixel_t           s2_eff;
    logic             dmem_eff;
    logic             row_first;
    logic             row_last;
    logic             col_first;
    logic             col_last;
    logic             x_prev_row;
    logic             x_prev_up;
    logic             x_prev_down;
    logic             off_1;
    logic             off_hm1;
    logic             off_h;
    logic             off_hp1;
    logic             any_strong;
    pixel_t           fin;
    logic             fin_strong;
    logic             cfg_wr;
    reg_index_t       cfg_idx;
    int unsigned      h_new;

    assign pready   = 1'b1;
    assign s_tready = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_index_t'(paddr[2]);

    always_comb
    begin
        case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DATA_W'(image_width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DATA_W'(image_height_reg);
            default:          prdata = '0;
        endcase
    end

    assign accept    = s_tvalid && s_tready;
    assign have_in   = (req_type_t'(s_tuser) == REQ_PIXEL);
    assign in_strong = (s_tdata == GRAY_STRONG);
    assign cnt_full  = (count_reg == h_reg + CNT_W'(1));
    assign cnt_eq_h  = (count_reg == h_reg);
    assign push      = accept && have_in;
    assign pop       = accept && (have_in ? cnt_full : (count_reg != '0));
    assign land      = count_reg - CNT_W'(pop);
    assign fifo_rd   = pop && (32'(count_reg) >= 32'd4);
    assign s2_eff    = fbyp_reg ? fbyp_val_reg : fq_reg;
    assign dmem_eff  = dbyp_reg ? dbyp_val_reg : dq_reg;

    assign row_first = (row_reg == '0);
    assign row_last  = (row_reg == hm1_reg);
    assign col_first = (col_reg == '0);
    assign col_last  = (col_reg == wm1_reg);

    // Decided neighbors in the previous column.
    assign x_prev_row  = (hm1_reg == '0) ? last_res_reg : wb_reg;
    assign x_prev_up   = wa_reg;
    assign x_prev_down = dmem_eff;

    // Incoming neighbors below and in the next column.
    assign off_1   = (count_reg >= CNT_W'(2)) && (s1_reg == GRAY_STRONG);
    assign off_hm1 = cnt_full ? last2_reg : (cnt_eq_h ? last1_reg : 1'b0);
    assign off_h   = cnt_full && last1_reg;
    assign off_hp1 = have_in && in_strong;

    assign any_strong =
        (!col_first && (x_prev_row || (!row_first && x_prev_up) ||
                        (!row_last && x_prev_down))) ||
        (!row_first && last_res_reg) ||
        (!row_last && off_1) ||
        (!col_last && (off_h || (!row_first && off_hm1) || (!row_last && off_hp1)));

    assign fin        = (s0_reg == GRAY_WEAK) ? (any_strong ? GRAY_STRONG : GRAY_BLACK)
                                              : s0_reg;
    assign fin_strong = (fin == GRAY_STRONG);

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        h_next            = h_reg;
        hm1_next          = hm1_reg;
        wm1_next          = wm1_reg;
        count_next        = count_reg;
        row_next          = row_reg;
        col_next          = col_reg;
        tail_next         = tail_reg;
        head3_next        = head3_reg;
        s0_next           = s0_reg;
        s1_next           = s1_reg;
        fbyp_next         = fbyp_reg;
        fbyp_val_next     = fbyp_val_reg;
        last1_next        = last1_reg;
        last2_next        = last2_reg;
        wp_next           = wp_reg;
        rp_next           = rp_reg;
        dbyp_next         = dbyp_reg;
        dbyp_val_next     = dbyp_val_reg;
        wa_next           = wa_reg;
        wb_next           = wb_reg;
        last_res_next     = last_res_reg;
        m_valid_next      = m_valid_reg;
        m_data_next       = m_data_reg;
        m_last_next       = m_last_reg;
        h_new             = 32'(h_reg);

        if (m_tready)
        begin
            m_valid_next = 1'b0;
        end

        if (pop)
        begin
            m_valid_next  = 1'b1;
            m_data_next   = fin;
            m_last_next   = row_last && col_last;
            s0_next       = s1_reg;
            s1_next       = s2_eff;
            if (fifo_rd)
            begin
                fbyp_next = 1'b0;
            end
            head3_next    = (head3_reg == FA_W'(FIFO_DEPTH - 1)) ? '0 : head3_reg + 1'b1;
            wp_next       = (wp_reg == DA_W'(DMEM_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            rp_next       = (rp_reg == DA_W'(DMEM_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            dbyp_next     = (rp_reg == wp_reg);
            dbyp_val_next = fin_strong;
            wa_next       = wb_reg;
            wb_next       = dmem_eff;
            last_res_next = fin_strong;
            if (row_last)
            begin
                row_next = '0;
                col_next = col_last ? '0 : col_reg + 1'b1;
            end
            else
            begin
                row_next = row_reg + 1'b1;
            end
        end

        if (push)
        begin
            tail_next  = (tail_reg == FA_W'(FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            last1_next = in_strong;
            last2_next = last1_reg;
            if (land == CNT_W'(0))
            begin
                s0_next = s_tdata;
            end
            else if (land == CNT_W'(1))
            begin
                s1_next = s_tdata;
            end
            else if (land == CNT_W'(2))
            begin
                fbyp_next     = 1'b1;
                fbyp_val_next = s_tdata;
            end
        end

        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);

        if (cfg_wr)
        begin
            case (cfg_idx)
                REG_IMAGE_WIDTH:
                begin
                    image_width_next = pwdata[IMG_WIDTH_W-1:0];
                    wm1_next = COL_W'(clamp_val(32'(pwdata[IMG_WIDTH_W-1:0]), MAX_WIDTH) - 1);
                end
                REG_IMAGE_HEIGHT:
                begin
                    image_height_next = pwdata[IMG_HEIGHT_W-1:0];
                    h_new    = clamp_val(32'(pwdata[IMG_HEIGHT_W-1:0]), MAX_HEIGHT);
                    h_next   = CNT_W'(h_new);
                    hm1_next = ROW_W'(h_new - 1);
                end
                default:
                begin
                    h_new = 32'(h_reg);
                end
            endcase
            count_next = '0;
            row_next   = '0;
            col_next   = '0;
            tail_next  = '0;
            head3_next = FA_W'(HEAD3_INIT);
            wp_next    = '0;
            rp_next    = rp_start(h_new);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= img_width_t'(RESET_WIDTH);
            image_height_reg <= img_height_t'(RESET_HEIGHT);
            h_reg            <= CNT_W'(RST_H);
            hm1_reg          <= ROW_W'(RST_H - 1);
            wm1_reg          <= COL_W'(RST_W - 1);
            count_reg        <= '0;
            row_reg          <= '0;
            col_reg          <= '0;
            tail_reg         <= '0;
            head3_reg        <= FA_W'(HEAD3_INIT);
            s0_reg           <= '0;
            s1_reg           <= '0;
            fbyp_reg         <= 1'b0;
            fbyp_val_reg     <= '0;
            last1_reg        <= 1'b0;
            last2_reg        <= 1'b0;
            wp_reg           <= '0;
            rp_reg           <= DA_W'(RST_RP);
            dbyp_reg         <= 1'b0;
            dbyp_val_reg     <= 1'b0;
            wa_reg           <= 1'b0;
            wb_reg           <= 1'b0;
            last_res_reg     <= 1'b0;
            m_valid_reg      <= 1'b0;
            m_data_reg       <= '0;
            m_last_reg       <= 1'b0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            h_reg            <= h_next;
            hm1_reg          <= hm1_next;
            wm1_reg          <= wm1_next;
            count_reg        <= count_next;
            row_reg          <= row_next;
            col_reg          <= col_next;
            tail_reg         <= tail_next;
            head3_reg        <= head3_next;
            s0_reg           <= s0_next;
            s1_reg           <= s1_next;
            fbyp_reg         <= fbyp_next;
            fbyp_val_reg     <= fbyp_val_next;
            last1_reg        <= last1_next;
            last2_reg        <= last2_next;
            wp_reg           <= wp_next;
            rp_reg           <= rp_next;
            dbyp_reg         <= dbyp_next;
            dbyp_val_reg     <= dbyp_val_next;
            wa_reg           <= wa_next;
            wb_reg           <= wb_next;
            last_res_reg     <= last_res_next;
            m_valid_reg      <= m_valid_next;
            m_data_reg       <= m_data_next;
            m_last_reg       <= m_last_next;
        end
    end

    // Pending pixel queue: written at the tail, read three places past the head.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            fifo_mem[tail_reg] <= s_tdata;
        end
        if (fifo_rd)
        begin
            fq_reg <= fifo_mem[head3_reg];
        end
    end

    // Decided strong bits, kept in decision order.
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            dec_mem[wp_reg] <= fin_strong;
            dq_reg          <= dec_mem[rp_reg];
        end
    end

endmodule

`default_nettype wire

/* sim/tb_hysteresis_edge_tracking.sv */
// ============================================================================
// tb_hysteresis_edge_tracking
// Self-checking testbench of the hysteresis edge tracking block.
// ============================================================================
// Pixel and drain transactions go in on the s_ stream. Each accepted input is
// fed to an edge tracker kept inside the testbench, and the final gray level
// it decides is queued. Every output transaction is checked against the oldest
// queued gray level and frame end flag. A short table of directed rows covers
// the register extremes, weak pixels with and without strong neighbors, a full
// queue, early drains, a drain with nothing pending and a frame wrap. Random
// frames follow: mostly small and well formed, some abandoned or chained, and
// some with out of range register values. Both stream sides idle at random,
// and the output side also holds off for a long stretch.
// ============================================================================
`default_nettype none

module tb_hysteresis_edge_tracking;

    timeunit 1ns;
    timeprecision 1ps;

    import het_pkg::*;

    localparam int MAX_ROWS     = 2048;
    localparam int MAX_COLS     = 4096;
    localparam int RANDOM_ITEMS = 1750;
    localparam int IDLE_LIMIT   = 2000;
    localparam int LONG_HOLD    = 300;
    localparam int SETTLE_WAIT  = 4;
    localparam int END_WAIT     = 20;

    typedef struct packed
    {
        pixel_t gray;
        logic   last;
    } gray_result_t;

    typedef enum logic
    {
        ROW_REG  = 1'b0,
        ROW_ITEM = 1'b1
    } row_kind_t;

    typedef enum logic
    {
        CHK_MODEL = 1'b0,
        CHK_FIXED = 1'b1
    } row_check_t;

    typedef struct
    {
        row_kind_t   kind;
        reg_index_t  idx;
        int unsigned value;
        req_type_t   req;
        pixel_t      px;
        row_check_t  chk;
        pixel_t      fixed_gray;
        logic        fixed_last;
    } directed_row_t;

    localparam int N_DIRECTED = 31;

    directed_row_t directed_rows [N_DIRECTED] = '{
        '{ROW_REG,  REG_IMAGE_WIDTH,  1,    REQ_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_HEIGHT, 1,    REQ_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd25,  CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd255, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd0,   CHK_FIXED, 8'd0,   1'b1},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_FIXED, 8'd255, 1'b1},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_FIXED, 8'd0,   1'b1},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'hAA,  CHK_MODEL, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_WIDTH,  8191, REQ_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_HEIGHT, 4095, REQ_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd255, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd25,  CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd128, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_FIXED, 8'd255, 1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_HEIGHT, 0,    REQ_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd25,  CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_FIXED, 8'd0,   1'b1},
        '{ROW_REG,  REG_IMAGE_WIDTH,  2,    REQ_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_REG,  REG_IMAGE_HEIGHT, 2,    REQ_PIXEL, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd25,  CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd255, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd25,  CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd25,  CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_PIXEL, 8'd127, CHK_MODEL, 8'd0,   1'b0},
        '{ROW_ITEM, REG_IMAGE_WIDTH,  0,    REQ_DRAIN, 8'd0,   CHK_MODEL, 8'd0,   1'b0}
    };

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    pixel_t      s_tdata  = '0;
    logic        s_tuser  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    pixel_t      m_tdata;
    logic        m_tlast;
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    apb_addr_t   paddr    = '0;
    apb_data_t   pwdata   = '0;
    apb_data_t   prdata;
    logic        pready;

    // Edge tracker state.
    int unsigned cfg_cols_raw = RESET_WIDTH;
    int unsigned cfg_rows_raw = RESET_HEIGHT;
    pixel_t      pending_gray [$];
    bit          row_strong [MAX_ROWS];
    bit          above_old_strong = 1'b0;
    int unsigned decided_pos = 0;

    gray_result_t final_gray_q [$];

    int          error_count   = 0;
    int unsigned items_sent    = 0;
    int unsigned results_seen  = 0;
    int unsigned frames_run    = 0;
    int unsigned reg_writes    = 0;
    int unsigned src_idle_pct  = 0;
    int unsigned sink_idle_pct = 0;
    bit          hold_go       = 1'b0;
    int unsigned hold_left     = 0;
    int unsigned quiet_cycles  = 0;

    hysteresis_edge_tracking #(
        .MAX_HEIGHT(MAX_ROWS),
        .MAX_WIDTH (MAX_COLS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always #5 clk = ~clk;

    function automatic int unsigned eff_cols();
        if (cfg_cols_raw < 1)
        begin
            return 1;
        end
        return (cfg_cols_raw > MAX_COLS) ? MAX_COLS : cfg_cols_raw;
    endfunction

    function automatic int unsigned eff_rows();
        if (cfg_rows_raw < 1)
        begin
            return 1;
        end
        return (cfg_rows_raw > MAX_ROWS) ? MAX_ROWS : cfg_rows_raw;
    endfunction

    // Strength of a pixel not yet decided, k places behind the oldest one.
    function automatic bit incoming_strong(int unsigned k, bit have_in, pixel_t in_px);
        if (k < pending_gray.size())
        begin
            return pending_gray[k] == GRAY_STRONG;
        end
        if (have_in && k == pending_gray.size())
        begin
            return in_px == GRAY_STRONG;
        end
        return 1'b0;
    endfunction

    function automatic gray_result_t decide_oldest_pixel(bit have_in, pixel_t in_px);
        int unsigned  w;
        int unsigned  h;
        int unsigned  col;
        int unsigned  row;
        bit           near;
        gray_result_t r;
        w      = eff_cols();
        h      = eff_rows();
        col    = decided_pos / h;
        row    = decided_pos % h;
        r.gray = pending_gray[0];
        if (r.gray == GRAY_WEAK)
        begin
            near = 1'b0;
            if (col > 0)
            begin
                near |= row_strong[row];
                if (row > 0)
                begin
                    near |= above_old_strong;
                end
                if (row + 1 < h)
                begin
                    near |= row_strong[row + 1];
                end
            end
            if (row > 0)
            begin
                near |= row_strong[row - 1];
            end
            if (row + 1 < h)
            begin
                near |= incoming_strong(1, have_in, in_px);
            end
            if (col + 1 < w)
            begin
                near |= incoming_strong(h, have_in, in_px);
                if (row > 0)
                begin
                    near |= incoming_strong(h - 1, have_in, in_px);
                end
                if (row + 1 < h)
                begin
                    near |= incoming_strong(h + 1, have_in, in_px);
                end
            end
            r.gray = near ? GRAY_STRONG : GRAY_BLACK;
        end
        above_old_strong = row_strong[row];
        row_strong[row]  = (r.gray == GRAY_STRONG);
        r.last           = (decided_pos + 1 >= w * h);
        decided_pos      = r.last ? 0 : decided_pos + 1;
        void'(pending_gray.pop_front());
        return r;
    endfunction

    function automatic bit track_item(req_type_t req, pixel_t px, output gray_result_t r);
        bit produced;
        produced = 1'b0;
        r        = '0;
        if (req == REQ_PIXEL)
        begin
            if (pending_gray.size() >= eff_rows() + 1)
            begin
                r        = decide_oldest_pixel(1'b1, px);
                produced = 1'b1;
            end
            pending_gray.push_back(px);
        end
        else if (pending_gray.size() > 0)
        begin
            r        = decide_oldest_pixel(1'b0, '0);
            produced = 1'b1;
        end
        return produced;
    endfunction

    function automatic pixel_t random_gray();
        int unsigned pick;
        pick = $urandom_range(99);
        if (pick < 45)
        begin
            return GRAY_WEAK;
        end
        if (pick < 70)
        begin
            return GRAY_STRONG;
        end
        if (pick < 82)
        begin
            return GRAY_BLACK;
        end
        return pixel_t'($urandom_range(255));
    endfunction

    task automatic send_item(input req_type_t req, input pixel_t px, input row_check_t chk,
                             input pixel_t fixed_gray, input logic fixed_last);
        gray_result_t r;
        bit           produced;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= req;
        s_tdata  <= px;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        items_sent++;
        produced = track_item(req, px, r);
        if (chk == CHK_FIXED)
        begin
            r.gray   = fixed_gray;
            r.last   = fixed_last;
            produced = 1'b1;
        end
        if (produced)
        begin
            final_gray_q.push_back(r);
        end
    endtask

    task automatic send_random(input req_type_t req, input pixel_t px);
        send_item(req, px, CHK_MODEL, '0, 1'b0);
    endtask

    // Stops the input side until every decided gray level has come out.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (final_gray_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_WAIT) @(posedge clk);
    endtask

    task automatic apb_write(input reg_index_t idx, input int unsigned value);
        int unsigned mask;
        mask     = (idx == REG_IMAGE_WIDTH) ? 32'h1FFF : 32'h0FFF;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= apb_addr_t'(int'(idx) * 4);
        pwdata  <= apb_data_t'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata != apb_data_t'(value & mask))
        begin
            $error("prdata mismatch: expected %0d, actual %0d", value & mask, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_IMAGE_WIDTH)
        begin
            cfg_cols_raw = value & mask;
        end
        else
        begin
            cfg_rows_raw = value & mask;
        end
        pending_gray.delete();
        decided_pos      = 0;
        above_old_strong = 1'b0;
        reg_writes++;
    endtask

    task automatic run_frame();
        int unsigned w;
        int unsigned h;
        int unsigned npix;
        int unsigned drains;
        bit          odd_regs;
        odd_regs = ($urandom_range(9) == 0);
        if (odd_regs || $urandom_range(99) < 60)
        begin
            if (odd_regs)
            begin
                w = $urandom_range(8191);
                h = $urandom_range(4095);
            end
            else if ($urandom_range(7) == 0)
            begin
                w = $urandom_range(1, 3);
                h = $urandom_range(1, 40);
            end
            else if ($urandom_range(7) == 0)
            begin
                w = $urandom_range(1, 40);
                h = $urandom_range(1, 2);
            end
            else
            begin
                w = $urandom_range(1, 6);
                h = $urandom_range(1, 6);
            end
            settle();
            apb_write(REG_IMAGE_WIDTH, w);
            apb_write(REG_IMAGE_HEIGHT, h);
        end
        npix = odd_regs ? $urandom_range(1, 24) : eff_cols() * eff_rows();
        if (npix > 300)
        begin
            npix = $urandom_range(1, 60);
        end
        if ($urandom_range(99) < 8)
        begin
            npix = $urandom_range(1, npix);
        end
        for (int k = 0; k < npix; k++)
        begin
            if ($urandom_range(99) < 3)
            begin
                send_random(REQ_DRAIN, pixel_t'($urandom_range(255)));
            end
            send_random(REQ_PIXEL, random_gray());
        end
        if (odd_regs || $urandom_range(99) < 65)
        begin
            drains = pending_gray.size() + $urandom_range(0, 2);
            for (int k = 0; k < drains; k++)
            begin
                send_random(REQ_DRAIN, pixel_t'($urandom_range(255)));
            end
        end
        frames_run++;
    endtask

    always @(posedge clk)
    begin
        if (hold_go)
        begin
            hold_go   = 1'b0;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    always @(posedge clk)
    begin
        gray_result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            results_seen++;
            if (final_gray_q.size() == 0)
            begin
                $error("output transaction with no result expected: pixel_out %0d", m_tdata);
                error_count++;
            end
            else
            begin
                want = final_gray_q.pop_front();
                if (m_tdata !== want.gray)
                begin
                    $error("pixel_out mismatch: expected %0d, actual %0d", want.gray, m_tdata);
                    error_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $error("frame_last mismatch: expected %0d, actual %0d", want.last, m_tlast);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        begin
            quiet_cycles = 0;
        end
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            if (directed_rows[i].kind == ROW_REG)
            begin
                settle();
                apb_write(directed_rows[i].idx, directed_rows[i].value);
            end
            else
            begin
                send_item(directed_rows[i].req, directed_rows[i].px, directed_rows[i].chk,
                          directed_rows[i].fixed_gray, directed_rows[i].fixed_last);
            end
        end

        for (int phase = 0; phase < 3; phase++)
        begin
            src_idle_pct  = (phase == 0) ? 11 : (phase == 1) ? 71 : 0;
            sink_idle_pct = (phase == 0) ? 71 : (phase == 1) ? 11 : 0;
            if (phase == 2)
            begin
                settle();
                hold_go = 1'b1;
            end
            while (items_sent < N_DIRECTED + (phase + 1) * RANDOM_ITEMS / 3)
            begin
                run_frame();
                if (phase == 1 && frames_run % 10 == 0)
                begin
                    settle();
                end
            end
        end

        settle();
        repeat (END_WAIT) @(posedge clk);
        $display("Ran %0d random frames and %0d register writes over %0d input transactions.",
                 frames_run, reg_writes, items_sent);
        $display("Checked %0d output transactions under three idle mixes and a long output stall.",
                 results_seen);
        if (error_count == 0 && final_gray_q.size() == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

`default_nettype wire
